>>> design/ectr_pkg.sv
`default_nettype none

package ectr_pkg;

   localparam int unsigned RING_DEPTH = 4096;
   localparam int unsigned MAX_DRAIN  = 63;

   localparam int unsigned IDX_W    = $clog2(RING_DEPTH);
   localparam int unsigned PTR_SPAN = 2 * RING_DEPTH;
   localparam int unsigned PTR_W    = $clog2(PTR_SPAN);
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned FILL_W   = 13;
   localparam int unsigned CNT_W    = 6;

   localparam logic [1:0] CMD_POLL  = 2'd0;
   localparam logic [1:0] CMD_EDGE  = 2'd1;
   localparam logic [1:0] CMD_DRAIN = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [TIME_W-1:0] timer_now;
      logic [CNT_W-1:0]  drain_cap;
   } ectr_req_type;

   typedef struct packed {
      logic              result_kind;
      logic [TIME_W-1:0] captured_time;
      logic [TIME_W-1:0] shadow_time;
      logic [TIME_W-1:0] capture_gap;
      logic [TIME_W-1:0] edge_number;
      logic [TIME_W-1:0] shadow_count;
      logic [TIME_W-1:0] edge_tally;
      logic [TIME_W-1:0] overflow_count;
      logic [FILL_W-1:0] fill_level;
      logic [CNT_W-1:0]  drained_count;
      logic              last_result;
   } ectr_rsp_type;

   // one ring entry as held in memory
   typedef struct packed {
      logic [TIME_W-1:0] captured_time;
      logic [TIME_W-1:0] shadow_time;
      logic [TIME_W-1:0] capture_gap;
      logic [TIME_W-1:0] edge_number;
      logic [TIME_W-1:0] shadow_count;
   } ectr_rec_type;

   localparam int unsigned REC_W = $bits(ectr_rec_type);

endpackage

`default_nettype wire

>>> design/ectr_ram.sv
`default_nettype none

module ectr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/ectr_core.sv
`default_nettype none

module ectr_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ectr_pkg::ectr_req_type req_data,
   output logic                       beat_valid,
   input  wire logic                  beat_ready,
   output ectr_pkg::ectr_rsp_type     beat_data
);

   import ectr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DRAIN  = 3'b010,
      ST_STATUS = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [TIME_W-1:0] edge_cnt_ff, edge_cnt_in;
   logic [TIME_W-1:0] ovf_cnt_ff, ovf_cnt_in;
   logic [TIME_W-1:0] shd_cnt_ff, shd_cnt_in;
   logic [TIME_W-1:0] cur_shd_ff, cur_shd_in;
   logic [TIME_W-1:0] lat_shd_ff, lat_shd_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [CNT_W-1:0]  drained_ff, drained_in;
   logic [TIME_W-1:0] cap_ff, cap_in;
   logic [TIME_W-1:0] dlt_ff, dlt_in;
   logic [TIME_W-1:0] num_ff, num_in;

   logic [PTR_W-1:0]  fill;
   logic              ring_full;
   logic [CNT_W-1:0]  limit;
   logic              mem_we;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   ectr_rec_type      mem_wdata;
   ectr_rec_type      mem_rdata;
   logic [REC_W-1:0]  mem_rdata_raw;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(PTR_SPAN - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] low;
      low = (ptr >= PTR_W'(RING_DEPTH)) ? ptr - PTR_W'(RING_DEPTH) : ptr;
      return low[IDX_W-1:0];
   endfunction

   // pointers run modulo twice the depth so full and empty differ
   assign fill = (wr_ptr_ff >= rd_ptr_ff) ? wr_ptr_ff - rd_ptr_ff
                                          : wr_ptr_ff - rd_ptr_ff + PTR_W'(PTR_SPAN);
   assign ring_full = (fill >= PTR_W'(RING_DEPTH));
   assign limit = (req_data.drain_cap < CNT_W'(MAX_DRAIN)) ? req_data.drain_cap
                                                           : CNT_W'(MAX_DRAIN);

   assign mem_wdata.captured_time = req_data.timer_now;
   assign mem_wdata.shadow_time   = cur_shd_ff;
   assign mem_wdata.capture_gap   = req_data.timer_now - cur_shd_ff;
   assign mem_wdata.edge_number   = edge_cnt_ff;
   assign mem_wdata.shadow_count  = shd_cnt_ff;
   assign mem_rdata = ectr_rec_type'(mem_rdata_raw);

   ectr_ram #(
      .WIDTH (REC_W),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (ptr_idx(wr_ptr_ff)),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata_raw)
   );

   always_comb begin
      state_in    = state_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      edge_cnt_in = edge_cnt_ff;
      ovf_cnt_in  = ovf_cnt_ff;
      shd_cnt_in  = shd_cnt_ff;
      cur_shd_in  = cur_shd_ff;
      lat_shd_in  = lat_shd_ff;
      remain_in   = remain_ff;
      drained_in  = drained_ff;
      cap_in      = cap_ff;
      dlt_in      = dlt_ff;
      num_in      = num_ff;
      req_ready   = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_raddr   = ptr_idx(rd_ptr_ff);
      beat_valid  = 1'b0;
      beat_data   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            // keep the oldest entry prefetched for a drain
            mem_re = 1'b1;
            if (req_valid && !reset) begin
               cap_in     = '0;
               dlt_in     = '0;
               num_in     = '0;
               drained_in = '0;
               state_in   = ST_STATUS;
               unique case (req_data.cmd)
                  CMD_POLL: begin
                     cur_shd_in = req_data.timer_now;
                     lat_shd_in = req_data.timer_now;
                     shd_cnt_in = shd_cnt_ff + TIME_W'(1);
                  end
                  CMD_EDGE: begin
                     cap_in = req_data.timer_now;
                     dlt_in = req_data.timer_now - cur_shd_ff;
                     num_in = edge_cnt_ff;
                     if (ring_full) begin
                        ovf_cnt_in = ovf_cnt_ff + TIME_W'(1);
                     end else begin
                        mem_we    = 1'b1;
                        wr_ptr_in = ptr_inc(wr_ptr_ff);
                     end
                     edge_cnt_in = edge_cnt_ff + TIME_W'(1);
                     cur_shd_in  = '0;
                  end
                  CMD_DRAIN: begin
                     remain_in = limit;
                     state_in  = ST_DRAIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (remain_ff == '0 || fill == '0) begin
               state_in = ST_STATUS;
            end else begin
               beat_valid              = 1'b1;
               beat_data.result_kind   = KIND_RECORD;
               beat_data.captured_time = mem_rdata.captured_time;
               beat_data.shadow_time   = mem_rdata.shadow_time;
               beat_data.capture_gap   = mem_rdata.capture_gap;
               beat_data.edge_number   = mem_rdata.edge_number;
               beat_data.shadow_count  = mem_rdata.shadow_count;
               if (beat_ready) begin
                  rd_ptr_in  = ptr_inc(rd_ptr_ff);
                  remain_in  = remain_ff - CNT_W'(1);
                  drained_in = drained_ff + CNT_W'(1);
                  // fetch the next entry so it is ready on the following cycle
                  mem_re    = 1'b1;
                  mem_raddr = ptr_idx(ptr_inc(rd_ptr_ff));
               end
            end
         end
         ST_STATUS: begin
            beat_valid               = 1'b1;
            beat_data.result_kind    = KIND_STATUS;
            beat_data.captured_time  = cap_ff;
            beat_data.shadow_time    = lat_shd_ff;
            beat_data.capture_gap    = dlt_ff;
            beat_data.edge_number    = num_ff;
            beat_data.shadow_count   = shd_cnt_ff;
            beat_data.edge_tally     = edge_cnt_ff;
            beat_data.overflow_count = ovf_cnt_ff;
            beat_data.fill_level     = FILL_W'(fill);
            beat_data.drained_count  = drained_ff;
            beat_data.last_result    = 1'b1;
            if (beat_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         edge_cnt_ff <= '0;
         ovf_cnt_ff  <= '0;
         shd_cnt_ff  <= '0;
         cur_shd_ff  <= '0;
         lat_shd_ff  <= '0;
         remain_ff   <= '0;
         drained_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         edge_cnt_ff <= edge_cnt_in;
         ovf_cnt_ff  <= ovf_cnt_in;
         shd_cnt_ff  <= shd_cnt_in;
         cur_shd_ff  <= cur_shd_in;
         lat_shd_ff  <= lat_shd_in;
         remain_ff   <= remain_in;
         drained_ff  <= drained_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
      dlt_ff <= dlt_in;
      num_ff <= num_in;
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= PTR_W'(RING_DEPTH))
      else $error("ring fill above depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (fill < PTR_W'(RING_DEPTH)))
      else $error("ring written while full");

   a_record_has_entry: assert property (@(posedge clock) disable iff (reset)
      (beat_valid && state_ff == ST_DRAIN) |-> (remain_ff != '0 && fill != '0))
      else $error("record beat without a held entry");

   a_drain_pops: assert property (@(posedge clock) disable iff (reset)
      (beat_valid && beat_ready && state_ff == ST_DRAIN)
      |=> (fill == $past(fill) - PTR_W'(1)))
      else $error("drained record did not leave the ring");

   a_drain_limit: assert property (@(posedge clock) disable iff (reset)
      drained_ff <= CNT_W'(MAX_DRAIN))
      else $error("drain emitted more than its limit");
`endif

endmodule

`default_nettype wire

>>> design/edge_timestamp_capture_ring_top.sv
// a taken request beat moves the core to status, whose beat the output register then
// presents on rsp; poll, edge and unused commands go via idle, where edges write the ring;
// a drain emits records then status, one record per cycle from the ring memory
// when the consumer holds ready, the registered read port being the pacing unit
// reset is synchronous and clears pointers, counters and shadows; ring contents
// are left as they are and no clearing pass runs, so a request is taken right after reset
`default_nettype none

module edge_timestamp_capture_ring_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ectr_pkg::ectr_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ectr_pkg::ectr_rsp_type      rsp_data
);

   import ectr_pkg::*;

   logic         beat_valid;
   logic         beat_ready;
   ectr_rsp_type beat_data;
   logic         rsp_valid_ff, rsp_valid_in;
   ectr_rsp_type rsp_data_ff, rsp_data_in;

   ectr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat_data  (beat_data)
   );

   // output register: takes a beat when empty or being emptied
   assign beat_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (beat_ready) begin
         rsp_valid_in = beat_valid;
         rsp_data_in  = beat_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
   import ectr_pkg::*;

   // not named in the package: the block takes it and only reports status
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   ectr_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   ectr_rsp_type rsp_data;

   edge_timestamp_capture_ring_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 400_000);
      $display("tb: FAIL");
      $finish;
   end

   // capture unit state as the block should hold it
   ectr_rec_type     ring_mem [RING_DEPTH];
   logic [PTR_W-1:0] wr_ptr            = '0;
   logic [PTR_W-1:0] rd_ptr            = '0;
   logic [63:0]      edge_cnt          = '0;
   logic [63:0]      ovf_cnt           = '0;
   logic [63:0]      poll_cnt          = '0;
   logic [63:0]      shadow_since_edge = '0;
   logic [63:0]      last_shadow       = '0;

   ectr_rsp_type results_due [$];
   int unsigned  mismatch_count = 0;
   int unsigned  beat_count     = 0;
   int unsigned  hold_cycles    = 0;
   bit           idling_on      = 1'b1;

   function automatic logic [FILL_W-1:0] ring_fill();
      return FILL_W'(wr_ptr - rd_ptr);
   endfunction

   task automatic predict_capture_unit(input ectr_req_type item);
      ectr_rsp_type st;
      ectr_rsp_type rec;
      ectr_rec_type slot;
      logic [63:0]  cap;
      logic [63:0]  dlt;
      logic [63:0]  num;
      int unsigned  limit;
      int unsigned  taken;
      cap   = '0;
      dlt   = '0;
      num   = '0;
      taken = 0;
      case (item.cmd)
         CMD_POLL: begin
            shadow_since_edge = item.timer_now;
            last_shadow       = item.timer_now;
            poll_cnt++;
         end
         CMD_EDGE: begin
            cap = item.timer_now;
            dlt = item.timer_now - shadow_since_edge;
            num = edge_cnt;
            if (ring_fill() >= RING_DEPTH) begin
               ovf_cnt++;
            end else begin
               slot.captured_time = cap;
               slot.shadow_time   = shadow_since_edge;
               slot.capture_gap   = dlt;
               slot.edge_number   = num;
               slot.shadow_count  = poll_cnt;
               ring_mem[wr_ptr[IDX_W-1:0]] = slot;
               wr_ptr++;
            end
            edge_cnt++;
            shadow_since_edge = '0;
         end
         CMD_DRAIN: begin
            limit = (item.drain_cap < MAX_DRAIN) ? item.drain_cap : MAX_DRAIN;
            while (taken < limit && ring_fill() != 0) begin
               slot              = ring_mem[rd_ptr[IDX_W-1:0]];
               rec               = '0;
               rec.result_kind   = KIND_RECORD;
               rec.captured_time = slot.captured_time;
               rec.shadow_time   = slot.shadow_time;
               rec.capture_gap   = slot.capture_gap;
               rec.edge_number   = slot.edge_number;
               rec.shadow_count  = slot.shadow_count;
               results_due.push_back(rec);
               taken++;
               rd_ptr++;
            end
         end
         default: ;
      endcase
      st                = '0;
      st.result_kind    = KIND_STATUS;
      st.captured_time  = cap;
      st.shadow_time    = last_shadow;
      st.capture_gap    = dlt;
      st.edge_number    = num;
      st.shadow_count   = poll_cnt;
      st.edge_tally     = edge_cnt;
      st.overflow_count = ovf_cnt;
      st.fill_level     = ring_fill();
      st.drained_count  = CNT_W'(taken);
      st.last_result    = 1'b1;
      results_due.push_back(st);
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50) $display("tb: mismatch at beat %0d: %s", beat_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      ectr_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = results_due.pop_front();
            check_field("result_kind", 64'(rsp_data.result_kind), 64'(want.result_kind));
            check_field("captured_time", rsp_data.captured_time, want.captured_time);
            check_field("shadow_time", rsp_data.shadow_time, want.shadow_time);
            check_field("capture_gap", rsp_data.capture_gap, want.capture_gap);
            check_field("edge_number", rsp_data.edge_number, want.edge_number);
            check_field("shadow_count", rsp_data.shadow_count, want.shadow_count);
            check_field("edge_tally", rsp_data.edge_tally, want.edge_tally);
            check_field("overflow_count", rsp_data.overflow_count, want.overflow_count);
            check_field("fill_level", 64'(rsp_data.fill_level), 64'(want.fill_level));
            check_field("drained_count", 64'(rsp_data.drained_count),
                        64'(want.drained_count));
            check_field("last_result", 64'(rsp_data.last_result), 64'(want.last_result));
         end
         beat_count++;
      end
   end

   // consumer side: a long hold-off wins over random stall bursts
   initial begin : rsp_side
      int unsigned burst;
      bit          stalling;
      burst    = 0;
      stalling = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (!idling_on) begin
            rsp_ready <= 1'b1;
         end else begin
            if (burst == 0) begin
               stalling = ($urandom_range(0, 2) == 0);
               burst    = stalling ? $urandom_range(1, 12) : $urandom_range(1, 20);
            end
            burst--;
            rsp_ready <= !stalling;
         end
      end
   end

   task automatic offer_req(input logic [1:0] cmd, input logic [63:0] now,
                            input logic [CNT_W-1:0] maxe);
      ectr_req_type item;
      int unsigned  gap;
      item.cmd       = cmd;
      item.timer_now = now;
      item.drain_cap = maxe;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_capture_unit(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   task automatic test_basic_sequences();
      offer_req(CMD_DRAIN, 64'd3, '1);                // empty ring
      offer_req(CMD_UNUSED, '1, 6'd17);
      offer_req(CMD_EDGE, 64'd5, '0);                 // no poll yet, shadow reads zero
      offer_req(CMD_POLL, '1, 6'd42);
      offer_req(CMD_EDGE, '0, '1);                    // delta wraps round
      offer_req(CMD_POLL, 64'd100, '0);
      offer_req(CMD_POLL, 64'd250, '0);
      offer_req(CMD_EDGE, 64'd1000, '0);
      offer_req(CMD_EDGE, 64'd2000, '0);              // shadow cleared by previous edge
      offer_req(CMD_DRAIN, 64'd2100, '0);             // status only
      offer_req(CMD_DRAIN, 64'd2200, 6'd1);
      offer_req(CMD_DRAIN, 64'd2300, '1);             // fewer held than asked
      offer_req(CMD_UNUSED, {$urandom, $urandom}, 6'($urandom));
      offer_req(CMD_DRAIN, '0, 6'd5);
   endtask

   task automatic test_edge_burst();
      logic [63:0] t;
      int unsigned i;
      t = {$urandom, $urandom};
      idling_on = 1'b0;
      for (i = 0; i < 10; i++) begin
         t = t + 64'($urandom_range(1, 1000));
         if (i % 4 == 0) offer_req(CMD_POLL, t, 6'($urandom));
         offer_req(CMD_EDGE, t + 64'($urandom_range(1, 50)), 6'($urandom));
      end
      idling_on = 1'b1;
      // small drains walk the ring out a few records at a time
      while (ring_fill() != 0)
         offer_req(CMD_DRAIN, t, CNT_W'($urandom_range(1, 4)));
      offer_req(CMD_DRAIN, t, '1);
   endtask

   task automatic test_output_stall();
      logic [63:0] t;
      int unsigned i;
      t = {$urandom, $urandom};
      idling_on   = 1'b0;
      hold_cycles = 300;
      for (i = 0; i < 24; i++) begin
         t = t + 64'($urandom_range(1, 500));
         case (i % 4)
            0:       offer_req(CMD_POLL, t, '0);
            3:       offer_req(CMD_DRAIN, t, 6'd3);
            default: offer_req(CMD_EDGE, t, '0);
         endcase
      end
      wait_drained();
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [63:0]      t;
      logic [1:0]       cmd;
      logic [CNT_W-1:0] maxe;
      int unsigned      i;
      int unsigned      pick;
      t = {$urandom, $urandom};
      for (i = 0; i < 50; i++) begin
         if (i == 25) wait_drained();
         if (i == 40) idling_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 30) cmd = CMD_POLL;
         else if (pick < 65) cmd = CMD_EDGE;
         else if (pick < 95) cmd = CMD_DRAIN;
         else cmd = CMD_UNUSED;
         // mostly a running timer, now and then a jump anywhere
         if ($urandom_range(0, 9) == 0) t = {$urandom, $urandom};
         else t = t + 64'($urandom_range(1, 100000));
         case ($urandom_range(0, 5))
            0:       maxe = '0;
            1:       maxe = '1;
            2:       maxe = 6'($urandom);
            default: maxe = CNT_W'($urandom_range(1, 8));
         endcase
         offer_req(cmd, t, maxe);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_sequences();
      test_edge_burst();
      test_output_stall();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);
      if (results_due.size() != 0) report_mismatch("expected results left over");
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
design/ectr_pkg.sv
design/ectr_ram.sv
design/ectr_core.sv
design/edge_timestamp_capture_ring_top.sv
tb/tb.sv
